/* design/sca_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stereo corner row aligner.
// No dependencies.
package sca_pkg;
    localparam int COORD_W = 16;
    localparam int IDX_W   = 5;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 72;

    typedef struct packed {
        logic               side;
        logic               fend;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } corner_t;

    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_SPAN   = 7'b0000010,
        ST_SORT   = 7'b0000100,
        ST_SEARCH = 7'b0001000,
        ST_MUL    = 7'b0010000,
        ST_JUDGE  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;
endpackage

/* design/sca_front.sv */
`timescale 1ns / 1ps
// Input side: accepts corner items and queues them for the back end.
// Depends on sca_pkg.
module sca_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sca_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          q_valid,
    input  logic                          q_pop,
    output sca_pkg::corner_t              q_item
);
    import sca_pkg::*;

    corner_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    corner_t    item;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        item.side = s_tuser;
        item.fend = s_tlast;
        item.x    = s_tdata[COORD_W-1:0];
        item.y    = s_tdata[2*COORD_W-1:COORD_W];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("queue fill lost an item");
endmodule

/* design/sca_back.sv */
`timescale 1ns / 1ps
// Back end: stores corners, picks axis, sorts, searches offsets, emits pairs.
// Depends on sca_pkg.
module sca_back #(
    parameter int MAX_CORNERS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  sca_pkg::corner_t               q_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sca_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import sca_pkg::*;

    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam int IW = (MAX_CORNERS > 2) ? $clog2(MAX_CORNERS) : 1;
    localparam int AW = CW + 1;
    localparam int TW = COORD_W + CW;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CORNERS);

    logic [2*COORD_W-1:0] l_reg [MAX_CORNERS];
    logic [2*COORD_W-1:0] r_reg [MAX_CORNERS];
    logic [2*COORD_W-1:0] l_next [MAX_CORNERS];
    logic [2*COORD_W-1:0] r_next [MAX_CORNERS];

    state_t state_reg, state_next;
    logic [CW-1:0] lcnt_reg, rcnt_reg, nl_reg, nr_reg;
    logic [CW-1:0] k_reg;
    logic [AW-1:0] idx_reg, adj_reg, sl_reg, sr_reg, bsl_reg, bsr_reg;
    logic [CW-1:0] bcnt_reg;
    logic [TW-1:0] tot_reg, btot_reg;
    logic [TW+CW-1:0] p1_reg, p2_reg;
    logic [COORD_W-1:0] lminx_reg, lmaxx_reg, lminy_reg, lmaxy_reg;
    logic [COORD_W-1:0] rminx_reg, rmaxx_reg, rminy_reg, rmaxy_reg;
    logic axis_reg, empty_reg;
    logic ov_reg;
    logic [TDATA_OUT_W-1:0] od_reg;
    logic ou_reg, ol_reg;

    logic out_free;
    logic [AW-1:0] la, ra;
    logic [2*COORD_W-1:0] le, re;
    logic [CW-1:0] lcnt_new, rcnt_new;
    logic [COORD_W-1:0] dif;
    logic [COORD_W:0] sx, sy;

    assign out_free = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
    assign m_tlast  = ol_reg;
    assign q_pop    = (state_reg == ST_LOAD) && q_valid;

    assign la = sl_reg + AW'(k_reg);
    assign ra = sr_reg + AW'(k_reg);
    assign le = l_reg[la[IW-1:0]];
    assign re = r_reg[ra[IW-1:0]];
    assign dif = (le[2*COORD_W-1:COORD_W] > re[2*COORD_W-1:COORD_W])
               ? le[2*COORD_W-1:COORD_W] - re[2*COORD_W-1:COORD_W]
               : re[2*COORD_W-1:COORD_W] - le[2*COORD_W-1:COORD_W];
    assign lcnt_new = (!q_item.side && lcnt_reg < MAXC) ? lcnt_reg + 1'b1 : lcnt_reg;
    assign rcnt_new = (q_item.side && rcnt_reg < MAXC) ? rcnt_reg + 1'b1 : rcnt_reg;
    assign sx = (lmaxx_reg - lminx_reg) + {1'b0, rmaxx_reg - rminx_reg};
    assign sy = (lmaxy_reg - lminy_reg) + {1'b0, rmaxy_reg - rminy_reg};

    function automatic logic [COORD_W-1:0] key_of(input logic [2*COORD_W-1:0] e,
                                                  input logic ax);
        return ax ? e[2*COORD_W-1:COORD_W] : e[COORD_W-1:0];
    endfunction

    always_comb
    begin
        for (int j = 0; j < MAX_CORNERS; j++)
        begin
            l_next[j] = l_reg[j];
            r_next[j] = r_reg[j];
        end
        for (int j = 0; j + 1 < MAX_CORNERS; j++)
        begin
            if ((j % 2) == int'(k_reg[0]))
            begin
                if (CW'(j + 1) < nl_reg &&
                    key_of(l_reg[j], axis_reg) > key_of(l_reg[j+1], axis_reg))
                begin
                    l_next[j]   = l_reg[j+1];
                    l_next[j+1] = l_reg[j];
                end
                if (CW'(j + 1) < nr_reg &&
                    key_of(r_reg[j], axis_reg) > key_of(r_reg[j+1], axis_reg))
                begin
                    r_next[j]   = r_reg[j+1];
                    r_next[j+1] = r_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && q_valid)
        begin
            if (!q_item.side && lcnt_reg < MAXC)
                l_reg[lcnt_reg[IW-1:0]] <= {q_item.y, q_item.x};
            if (q_item.side && rcnt_reg < MAXC)
                r_reg[rcnt_reg[IW-1:0]] <= {q_item.y, q_item.x};
        end
        else if (state_reg == ST_SORT && k_reg != '0)
        begin
            for (int j = 0; j < MAX_CORNERS; j++)
            begin
                l_reg[j] <= l_next[j];
                r_reg[j] <= r_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            lcnt_reg  <= '0;
            rcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (q_valid)
                    begin
                        lcnt_reg <= q_item.fend ? '0 : lcnt_new;
                        rcnt_reg <= q_item.fend ? '0 : rcnt_new;
                        if (q_item.fend)
                        begin
                            nl_reg    <= lcnt_new;
                            nr_reg    <= rcnt_new;
                            empty_reg <= (lcnt_new == '0) || (rcnt_new == '0);
                            k_reg     <= '0;
                            sl_reg    <= '0;
                            sr_reg    <= '0;
                        end
                    end
                end
                ST_SPAN:
                begin
                    if (k_reg < nl_reg)
                    begin
                        if (k_reg == '0 || le[COORD_W-1:0] < lminx_reg) lminx_reg <= le[COORD_W-1:0];
                        if (k_reg == '0 || le[COORD_W-1:0] > lmaxx_reg) lmaxx_reg <= le[COORD_W-1:0];
                        if (k_reg == '0 || le[2*COORD_W-1:COORD_W] < lminy_reg)
                            lminy_reg <= le[2*COORD_W-1:COORD_W];
                        if (k_reg == '0 || le[2*COORD_W-1:COORD_W] > lmaxy_reg)
                            lmaxy_reg <= le[2*COORD_W-1:COORD_W];
                    end
                    if (k_reg < nr_reg)
                    begin
                        if (k_reg == '0 || re[COORD_W-1:0] < rminx_reg) rminx_reg <= re[COORD_W-1:0];
                        if (k_reg == '0 || re[COORD_W-1:0] > rmaxx_reg) rmaxx_reg <= re[COORD_W-1:0];
                        if (k_reg == '0 || re[2*COORD_W-1:COORD_W] < rminy_reg)
                            rminy_reg <= re[2*COORD_W-1:COORD_W];
                        if (k_reg == '0 || re[2*COORD_W-1:COORD_W] > rmaxy_reg)
                            rmaxy_reg <= re[2*COORD_W-1:COORD_W];
                    end
                    k_reg <= (k_reg == MAXC - 1'b1) ? '0 : k_reg + 1'b1;
                end
                ST_SORT:
                begin
                    if (k_reg == '0)
                        axis_reg <= !(sx > sy);
                    if (k_reg == MAXC)
                    begin
                        k_reg   <= '0;
                        idx_reg <= '0;
                        adj_reg <= AW'(((nl_reg < nr_reg) ? nl_reg : nr_reg) >> 1);
                        sl_reg  <= '0;
                        sr_reg  <= '0;
                        tot_reg <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_SEARCH:
                begin
                    if (la < AW'(nl_reg) && ra < AW'(nr_reg))
                    begin
                        tot_reg <= tot_reg + TW'(dif);
                        k_reg   <= k_reg + 1'b1;
                    end
                end
                ST_MUL:
                begin
                    p1_reg <= tot_reg * bcnt_reg;
                    p2_reg <= btot_reg * k_reg;
                end
                ST_JUDGE:
                begin
                    if (idx_reg == '0 || p1_reg < p2_reg)
                    begin
                        btot_reg <= tot_reg;
                        bcnt_reg <= k_reg;
                        bsl_reg  <= sl_reg;
                        bsr_reg  <= sr_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    tot_reg <= '0;
                    if (idx_reg == {adj_reg[AW-2:0], 1'b0})
                    begin
                        k_reg <= '0;
                        if (idx_reg == '0 || p1_reg < p2_reg)
                        begin
                            sl_reg <= sl_reg;
                            sr_reg <= sr_reg;
                        end
                        else
                        begin
                            sl_reg <= bsl_reg;
                            sr_reg <= bsr_reg;
                        end
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (idx_reg + 1'b1 < adj_reg)
                        begin
                            sl_reg <= idx_reg + 1'b1;
                            sr_reg <= '0;
                        end
                        else
                        begin
                            sl_reg <= '0;
                            sr_reg <= idx_reg + 1'b1 - adj_reg;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (empty_reg)
                        begin
                            od_reg <= '0;
                            ou_reg <= 1'b1;
                            ol_reg <= 1'b1;
                        end
                        else
                        begin
                            od_reg <= {3'b000, re[2*COORD_W-1:COORD_W], re[COORD_W-1:0],
                                       le[2*COORD_W-1:COORD_W], le[COORD_W-1:0],
                                       IDX_W'(k_reg)};
                            ou_reg <= 1'b0;
                            ol_reg <= (k_reg + 1'b1 == bcnt_reg);
                            k_reg  <= k_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (q_valid && q_item.fend)
                    state_next = ((lcnt_new == '0) || (rcnt_new == '0)) ? ST_EMIT : ST_SPAN;
            ST_SPAN:
                if (k_reg == MAXC - 1'b1)
                    state_next = ST_SORT;
            ST_SORT:
                if (k_reg == MAXC)
                    state_next = ST_SEARCH;
            ST_SEARCH:
                if (!(la < AW'(nl_reg) && ra < AW'(nr_reg)))
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_JUDGE;
            ST_JUDGE:
                state_next = (idx_reg == {adj_reg[AW-2:0], 1'b0}) ? ST_EMIT : ST_SEARCH;
            ST_EMIT:
                if (out_free && (empty_reg || k_reg + 1'b1 == bcnt_reg))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        lcnt_reg <= MAXC && rcnt_reg <= MAXC)
        else $error("corner count beyond store depth");
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !empty_reg) |-> k_reg < bcnt_reg)
        else $error("pair index past overlap");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !q_pop)
        else $error("queue popped during alignment");
endmodule

/* design/stereo_corner_row_align.sv */
`timescale 1ns / 1ps
// Top level of the stereo corner row aligner.
// Depends on sca_pkg, sca_front, sca_back.
//
// channel  direction  payload
// s_axis   in         tdata {pos_y, pos_x}, tuser side, tlast frame_end
// m_axis   out        tdata {pad, right_y, right_x, left_y, left_x, pair_index},
//                     tuser empty_res, tlast run_end
//
// Each corner passes through a two-item queue before the back end stores it.
// At frame end the back end finds the spreads, runs an odd-even sort,
// tries each offset over the overlap, then emits the pairs.
// Reset clears counts and queue; stores need no clearing.
// Output stalls hold the result register; the queue absorbs up to two items meanwhile.
module stereo_corner_row_align #(
    parameter int MAX_CORNERS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pos_x, pos_y
    input  logic        s_axis_tuser,  // side
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // pair_index, left_x, left_y, right_x, right_y, pad
    output logic        m_axis_tuser,  // empty_res
    output logic        m_axis_tlast
);
    import sca_pkg::*;

    logic    q_valid, q_pop;
    corner_t q_item;

    sca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .s_tlast  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sca_back #(
        .MAX_CORNERS (MAX_CORNERS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );
endmodule
